// File: hdl/nnstc_pkg.sv
// Shared types and constants of the nearest-neighbor square compositor.
package nnstc_pkg;

   localparam int COORD_W = 12;
   localparam int PIXEL_W = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 13;
   localparam int SRC_REG_W = 10;
   localparam int CANVAS_REG_W = 13;
   localparam int CHAN_REG_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 3'd4;

   localparam logic [SRC_REG_W-1:0]    RST_SOURCE_WIDTH  = 10'd512;
   localparam logic [SRC_REG_W-1:0]    RST_SOURCE_HEIGHT = 10'd512;
   localparam logic [CANVAS_REG_W-1:0] RST_CANVAS_WIDTH  = 13'd1920;
   localparam logic [CANVAS_REG_W-1:0] RST_CANVAS_HEIGHT = 13'd1080;
   localparam logic [CHAN_REG_W-1:0]   RST_CHANNEL_COUNT = 3'd1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CHAN_REG_W-1:0] CHAN_FORCE_WHITE = 3'd2;
   localparam logic [PIXEL_W-1:0] WHITE = 8'd255;
   localparam logic [PIXEL_W-1:0] BLACK = 8'd0;
   localparam logic [PIXEL_W-1:0] THRESH = 8'd128;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIVY,
      S_DIVX,
      S_RD,
      S_WAIT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: hdl/nnstc_if.sv
// Request and response channel interfaces of the compositor.
interface nnstc_req_if;
   logic valid;
   logic ready;
   logic op;
   logic [nnstc_pkg::COORD_W-1:0] col;
   logic [nnstc_pkg::COORD_W-1:0] row;
   logic [nnstc_pkg::PIXEL_W-1:0] pixel;

   modport source (output valid, output op, output col, output row, output pixel,
                   input ready);
   modport sink (input valid, input op, input col, input row, input pixel,
                 output ready);
endinterface

interface nnstc_rsp_if;
   logic valid;
   logic ready;
   logic [nnstc_pkg::PIXEL_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// File: hdl/nnstc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nnstc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/nnstc_div.sv
// Restoring divider, one quotient bit per cycle; quotient known to fit QW bits.
module nnstc_div #(
   parameter int NW = 22,
   parameter int DW = 13,
   parameter int QW = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nnstc_pkg::div_ctrl_type ctrl,
   input  logic [NW-1:0]          numer,
   input  logic [DW-1:0]          denom,
   output nnstc_pkg::div_stat_type stat,
   output logic [QW-1:0]          quot
);

   localparam int CNTW = $clog2(QW + 1);

   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   den_ff, den_in;
   logic [QW-1:0]   num_ff, num_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DW:0]     trial;
   logic [DW:0]     diff;
   logic            ge;

   always_comb begin
      trial = {rem_ff, num_ff[QW-1]};
      diff = trial - {1'b0, den_ff};
      ge = trial >= {1'b0, den_ff};
      rem_in = rem_ff;
      den_in = den_ff;
      num_in = num_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in = DW'(numer >> QW);
         den_in = denom;
         num_in = numer[QW-1:0];
         q_in = '0;
         cnt_in = CNTW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         num_in = num_ff << 1;
         q_in = {q_ff[QW-2:0], ge};
         cnt_in = cnt_ff - CNTW'(1);
         busy_in = cnt_ff != CNTW'(1);
         done_in = cnt_ff == CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
      q_ff <= q_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot = q_ff;

endmodule

// File: hdl/nn_scale_threshold_center_compose.sv
// Top level: mask store and canvas reader with a shared iterative divider.
//
// A grayscale mask is loaded one pixel per beat on req_bus (op = load) and
// read back through a centered square canvas (op = read), one value per read
// beat on rsp_bus. A load gives no response; its pixel is forced to 255 when
// the channel count is 2. A read outside the square goes from the check state
// to the output state and answers 255. A read inside runs two divisions on one
// restoring divider, one quotient bit per cycle, then one RAM read.
// req_bus.ready is high only while no item is in flight, so a read holds the
// block until its response beat is taken; a stalled rsp_bus holds value.
// The csr port writes registers 0..4 (source width/height, canvas
// width/height, channel count); other indexes are ignored. The user must
// write them only while idle; the block itself does not enforce it.
// Reset is synchronous, restores register defaults and idles the sequencer.
// The mask RAM is not cleared; entries read before being loaded are undefined.
module nn_scale_threshold_center_compose #(
   parameter int MAX_SOURCE_DIM = 512,
   parameter int MAX_CANVAS_DIM = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   nnstc_req_if.sink                           req_bus,
   nnstc_rsp_if.source                         rsp_bus,
   input  logic                                csr_wr_en,
   input  logic [nnstc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [nnstc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int SDW = $clog2(MAX_SOURCE_DIM + 1);
   localparam int CDW = $clog2(MAX_CANVAS_DIM + 1);
   localparam int QW = $clog2(MAX_SOURCE_DIM);
   localparam int KW = (CDW > nnstc_pkg::COORD_W) ? CDW : nnstc_pkg::COORD_W;
   localparam int NW = CDW + SDW;
   localparam int DEPTH = MAX_SOURCE_DIM * MAX_SOURCE_DIM;
   localparam int AW = $clog2(DEPTH);

   nnstc_pkg::state_type state_ff, state_in;

   logic [nnstc_pkg::SRC_REG_W-1:0]    sw_raw_ff;
   logic [nnstc_pkg::SRC_REG_W-1:0]    sh_raw_ff;
   logic [nnstc_pkg::CANVAS_REG_W-1:0] cw_raw_ff;
   logic [nnstc_pkg::CANVAS_REG_W-1:0] ch_raw_ff;
   logic [nnstc_pkg::CHAN_REG_W-1:0]   chan_ff;

   logic [nnstc_pkg::COORD_W-1:0] col_ff, col_in;
   logic [nnstc_pkg::COORD_W-1:0] row_ff, row_in;
   logic [CDW-1:0]                lx_ff, lx_in;
   logic [QW-1:0]                 sy_ff, sy_in;
   logic [QW-1:0]                 sx_ff, sx_in;
   logic [nnstc_pkg::PIXEL_W-1:0] value_ff, value_in;

   logic [SDW-1:0] sw_c, sh_c;
   logic [CDW-1:0] cw_c, side_c, off_c;
   logic [KW-1:0]  col_k, row_k, cw_k, side_k, off_k, lx_k;
   logic           in_square;

   logic [CDW-1:0] mul_a;
   logic [SDW-1:0] mul_b;
   logic [NW-1:0]  product;
   logic [QW-1:0]  quot;
   logic [QW-1:0]  quot_clamp;
   logic [SDW-1:0] quot_lim;

   nnstc_pkg::div_ctrl_type div_ctrl;
   nnstc_pkg::div_stat_type div_stat;

   logic                          req_accept;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [nnstc_pkg::PIXEL_W-1:0] wr_data;
   logic                          rd_en;
   logic [AW-1:0]                 rd_addr;
   logic [nnstc_pkg::PIXEL_W-1:0] rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_raw_ff <= nnstc_pkg::RST_SOURCE_WIDTH;
         sh_raw_ff <= nnstc_pkg::RST_SOURCE_HEIGHT;
         cw_raw_ff <= nnstc_pkg::RST_CANVAS_WIDTH;
         ch_raw_ff <= nnstc_pkg::RST_CANVAS_HEIGHT;
         chan_ff <= nnstc_pkg::RST_CHANNEL_COUNT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            nnstc_pkg::CSR_SOURCE_WIDTH: begin
               sw_raw_ff <= csr_data[nnstc_pkg::SRC_REG_W-1:0];
            end
            nnstc_pkg::CSR_SOURCE_HEIGHT: begin
               sh_raw_ff <= csr_data[nnstc_pkg::SRC_REG_W-1:0];
            end
            nnstc_pkg::CSR_CANVAS_WIDTH: begin
               cw_raw_ff <= csr_data[nnstc_pkg::CANVAS_REG_W-1:0];
            end
            nnstc_pkg::CSR_CANVAS_HEIGHT: begin
               ch_raw_ff <= csr_data[nnstc_pkg::CANVAS_REG_W-1:0];
            end
            nnstc_pkg::CSR_CHANNEL_COUNT: begin
               chan_ff <= csr_data[nnstc_pkg::CHAN_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // saturated geometry
   always_comb begin
      if (sw_raw_ff == '0) begin
         sw_c = SDW'(1);
      end else if (32'(sw_raw_ff) > MAX_SOURCE_DIM) begin
         sw_c = SDW'(MAX_SOURCE_DIM);
      end else begin
         sw_c = SDW'(sw_raw_ff);
      end
      if (sh_raw_ff == '0) begin
         sh_c = SDW'(1);
      end else if (32'(sh_raw_ff) > MAX_SOURCE_DIM) begin
         sh_c = SDW'(MAX_SOURCE_DIM);
      end else begin
         sh_c = SDW'(sh_raw_ff);
      end
      cw_c = (32'(cw_raw_ff) > MAX_CANVAS_DIM) ? CDW'(MAX_CANVAS_DIM) : CDW'(cw_raw_ff);
      side_c = (32'(ch_raw_ff) > MAX_CANVAS_DIM) ? CDW'(MAX_CANVAS_DIM) : CDW'(ch_raw_ff);
      off_c = (cw_c > side_c) ? CDW'((cw_c - side_c) >> 1) : '0;
      col_k = KW'(col_ff);
      row_k = KW'(row_ff);
      cw_k = KW'(cw_c);
      side_k = KW'(side_c);
      off_k = KW'(off_c);
      lx_k = col_k - off_k;
      in_square = (col_k < cw_k) && (row_k < side_k) && (col_k >= off_k)
                  && (lx_k < side_k);
   end

   // shared multiplier feeding the divider
   always_comb begin
      if (state_ff == nnstc_pkg::S_CHECK) begin
         mul_a = CDW'(row_ff);
         mul_b = sh_c;
         quot_lim = sh_c;
      end else begin
         mul_a = lx_ff;
         mul_b = sw_c;
         quot_lim = (state_ff == nnstc_pkg::S_DIVY) ? sh_c : sw_c;
      end
      product = NW'(mul_a) * NW'(mul_b);
      quot_clamp = (32'(quot) >= 32'(quot_lim)) ? QW'(quot_lim - SDW'(1)) : quot;
   end

   nnstc_div #(
      .NW(NW),
      .DW(CDW),
      .QW(QW)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .ctrl(div_ctrl),
      .numer(product),
      .denom(side_c),
      .stat(div_stat),
      .quot(quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nnstc_pkg::S_IDLE: begin
            if (req_accept && req_bus.op == nnstc_pkg::OP_READ) begin
               state_in = nnstc_pkg::S_CHECK;
            end
         end
         nnstc_pkg::S_CHECK: begin
            state_in = in_square ? nnstc_pkg::S_DIVY : nnstc_pkg::S_OUT;
         end
         nnstc_pkg::S_DIVY: begin
            if (div_stat.done) begin
               state_in = nnstc_pkg::S_DIVX;
            end
         end
         nnstc_pkg::S_DIVX: begin
            if (div_stat.done) begin
               state_in = nnstc_pkg::S_RD;
            end
         end
         nnstc_pkg::S_RD: begin
            state_in = nnstc_pkg::S_WAIT;
         end
         nnstc_pkg::S_WAIT: begin
            state_in = nnstc_pkg::S_OUT;
         end
         nnstc_pkg::S_OUT: begin
            if (rsp_bus.ready) begin
               state_in = nnstc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = nnstc_pkg::S_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;
      div_ctrl.start = 1'b0;
      rd_en = 1'b0;
      unique case (state_ff)
         nnstc_pkg::S_IDLE: begin
            req_bus.ready = 1'b1;
         end
         nnstc_pkg::S_CHECK: begin
            div_ctrl.start = in_square;
         end
         nnstc_pkg::S_DIVY: begin
            div_ctrl.start = div_stat.done;
         end
         nnstc_pkg::S_RD: begin
            rd_en = 1'b1;
         end
         nnstc_pkg::S_OUT: begin
            rsp_bus.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      req_accept = req_bus.valid && req_bus.ready;
      col_in = col_ff;
      row_in = row_ff;
      lx_in = lx_ff;
      sy_in = sy_ff;
      sx_in = sx_ff;
      value_in = value_ff;
      if (req_accept) begin
         col_in = req_bus.col;
         row_in = req_bus.row;
      end
      if (state_ff == nnstc_pkg::S_CHECK) begin
         lx_in = CDW'(lx_k);
         value_in = nnstc_pkg::WHITE;
      end
      if (state_ff == nnstc_pkg::S_DIVY && div_stat.done) begin
         sy_in = quot_clamp;
      end
      if (state_ff == nnstc_pkg::S_DIVX && div_stat.done) begin
         sx_in = quot_clamp;
      end
      if (state_ff == nnstc_pkg::S_WAIT) begin
         value_in = (rd_data < nnstc_pkg::THRESH) ? nnstc_pkg::BLACK : nnstc_pkg::WHITE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nnstc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      col_ff <= col_in;
      row_ff <= row_in;
      lx_ff <= lx_in;
      sy_ff <= sy_in;
      sx_ff <= sx_in;
      value_ff <= value_in;
   end

   // mask store
   always_comb begin
      wr_en = req_accept && req_bus.op == nnstc_pkg::OP_LOAD
              && 32'(req_bus.col) < MAX_SOURCE_DIM && 32'(req_bus.row) < MAX_SOURCE_DIM;
      wr_addr = AW'(32'(req_bus.row) * MAX_SOURCE_DIM + 32'(req_bus.col));
      wr_data = (chan_ff == nnstc_pkg::CHAN_FORCE_WHITE) ? nnstc_pkg::WHITE : req_bus.pixel;
      rd_addr = AW'(32'(sy_ff) * MAX_SOURCE_DIM + 32'(sx_ff));
   end

   nnstc_ram #(
      .WIDTH(nnstc_pkg::PIXEL_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_bus.value = value_ff;

   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_read_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_bus.op == nnstc_pkg::OP_READ) |=> !rsp_bus.valid)
      else $error("response before read was processed");

   a_rsp_binary: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.value == nnstc_pkg::BLACK || rsp_bus.value == nnstc_pkg::WHITE))
      else $error("response value not black or white");

   a_no_accept_in_flight: assert property (@(posedge clock) disable iff (reset)
      (div_stat.busy || rsp_bus.valid) |-> !req_bus.ready)
      else $error("request accepted while a read is in flight");

endmodule

// File: bench/nnstc_canvas_checker.sv
`timescale 1ns / 1ps
// Checker for the compositor: mirrors mask and registers, predicts read values, compares.
module nnstc_canvas_checker #(
   parameter int MASK_DIM = 512,
   parameter int CANVAS_MAX = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   nnstc_req_if                              req_mon,
   nnstc_rsp_if                              rsp_mon,
   input  logic                              csr_wr_en,
   input  logic [nnstc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nnstc_pkg::CSR_DATA_W-1:0]  csr_data,
   output int unsigned                       fail_count,
   output int unsigned                       pending_count
);

   logic [nnstc_pkg::SRC_REG_W-1:0]    src_w;
   logic [nnstc_pkg::SRC_REG_W-1:0]    src_h;
   logic [nnstc_pkg::CANVAS_REG_W-1:0] cnv_wid;
   logic [nnstc_pkg::CANVAS_REG_W-1:0] cnv_hgt;
   logic [nnstc_pkg::CHAN_REG_W-1:0]   channels;
   logic [nnstc_pkg::PIXEL_W-1:0]      mask_ram [0:MASK_DIM*MASK_DIM-1];
   logic [nnstc_pkg::PIXEL_W-1:0]      expected_values [$];
   int unsigned                        mismatches = 0;
   int unsigned                        waiting = 0;

   assign fail_count = mismatches;
   assign pending_count = waiting;

   function automatic logic [nnstc_pkg::PIXEL_W-1:0] canvas_value(
         input logic [nnstc_pkg::COORD_W-1:0] col,
         input logic [nnstc_pkg::COORD_W-1:0] row);
      int unsigned sw;
      int unsigned sh;
      int unsigned cw;
      int unsigned side;
      int unsigned off;
      int unsigned lx;
      int unsigned sx;
      int unsigned sy;
      logic [nnstc_pkg::PIXEL_W-1:0] sample;
      sw = (src_w == 0) ? 1 : ((src_w > MASK_DIM) ? MASK_DIM : src_w);
      sh = (src_h == 0) ? 1 : ((src_h > MASK_DIM) ? MASK_DIM : src_h);
      cw = (cnv_wid > CANVAS_MAX) ? CANVAS_MAX : cnv_wid;
      side = (cnv_hgt > CANVAS_MAX) ? CANVAS_MAX : cnv_hgt;
      off = (cw > side) ? (cw - side) / 2 : 0;
      if (col >= cw || row >= side || col < off) return nnstc_pkg::WHITE;
      lx = col - off;
      if (lx >= side) return nnstc_pkg::WHITE;
      sy = (row * sh) / side;
      if (sy >= sh) sy = sh - 1;
      sx = (lx * sw) / side;
      if (sx >= sw) sx = sw - 1;
      sample = mask_ram[sy * MASK_DIM + sx];
      return (sample < nnstc_pkg::THRESH) ? nnstc_pkg::BLACK : nnstc_pkg::WHITE;
   endfunction

   always @(posedge clock) begin : watch
      logic [nnstc_pkg::PIXEL_W-1:0] want;
      if (reset) begin
         src_w = nnstc_pkg::RST_SOURCE_WIDTH;
         src_h = nnstc_pkg::RST_SOURCE_HEIGHT;
         cnv_wid = nnstc_pkg::RST_CANVAS_WIDTH;
         cnv_hgt = nnstc_pkg::RST_CANVAS_HEIGHT;
         channels = nnstc_pkg::RST_CHANNEL_COUNT;
         expected_values.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               nnstc_pkg::CSR_SOURCE_WIDTH: src_w = csr_data[nnstc_pkg::SRC_REG_W-1:0];
               nnstc_pkg::CSR_SOURCE_HEIGHT: src_h = csr_data[nnstc_pkg::SRC_REG_W-1:0];
               nnstc_pkg::CSR_CANVAS_WIDTH: cnv_wid = csr_data[nnstc_pkg::CANVAS_REG_W-1:0];
               nnstc_pkg::CSR_CANVAS_HEIGHT: cnv_hgt = csr_data[nnstc_pkg::CANVAS_REG_W-1:0];
               nnstc_pkg::CSR_CHANNEL_COUNT: channels = csr_data[nnstc_pkg::CHAN_REG_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.op == nnstc_pkg::OP_LOAD) begin
               if (req_mon.col < MASK_DIM && req_mon.row < MASK_DIM) begin
                  mask_ram[req_mon.row * MASK_DIM + req_mon.col] =
                     (channels == nnstc_pkg::CHAN_FORCE_WHITE) ? nnstc_pkg::WHITE
                                                               : req_mon.pixel;
               end
            end else begin
               expected_values.push_back(canvas_value(req_mon.col, req_mon.row));
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_values.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response beat, expected none, got value %0d",
                        $time, rsp_mon.value);
            end else begin
               want = expected_values.pop_front();
               if (rsp_mon.value !== want) begin
                  mismatches++;
                  $display("%0t: value mismatch, expected %0d, got %0d",
                           $time, want, rsp_mon.value);
               end
            end
         end
      end
      waiting = expected_values.size();
   end

endmodule

// File: bench/nn_scale_threshold_center_compose_test.sv
`timescale 1ns / 1ps
// Testbench top: drives mask loads, canvas reads and register writes, and gives the verdict.
module nn_scale_threshold_center_compose_test;

   localparam int MASK_DIM = 512;
   localparam int CANVAS_MAX = 4096;
   localparam int RANDOM_PHASES = 10;
   localparam int ITEMS_PER_PHASE = 105;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [nnstc_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_LO = 3'd5;
   localparam logic [nnstc_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_HI = 3'd7;

   typedef logic [nnstc_pkg::COORD_W-1:0]     coord_type;
   typedef logic [nnstc_pkg::PIXEL_W-1:0]     pixel_type;
   typedef logic [nnstc_pkg::CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [nnstc_pkg::CSR_DATA_W-1:0]  csr_data_type;

   typedef enum int {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC
   } stall_mode_type;

   logic                               clock;
   logic                               reset;
   logic                               csr_wr_en;
   logic [nnstc_pkg::CSR_INDEX_W-1:0]  csr_index;
   logic [nnstc_pkg::CSR_DATA_W-1:0]   csr_data;
   int unsigned                        fail_count;
   int unsigned                        pending_count;

   logic [nnstc_pkg::SRC_REG_W-1:0]    cfg_src_w;
   logic [nnstc_pkg::SRC_REG_W-1:0]    cfg_src_h;
   logic [nnstc_pkg::CANVAS_REG_W-1:0] cfg_canvas_w;
   logic [nnstc_pkg::CANVAS_REG_W-1:0] cfg_canvas_h;
   bit                                 loaded [0:MASK_DIM*MASK_DIM-1];
   int unsigned                        burst_left;
   int unsigned                        beats_sent;
   bit                                 gaps_on;

   nnstc_req_if req_bus ();
   nnstc_rsp_if rsp_bus ();

   nn_scale_threshold_center_compose #(
      .MAX_SOURCE_DIM(MASK_DIM),
      .MAX_CANVAS_DIM(CANVAS_MAX)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   nnstc_canvas_checker #(
      .MASK_DIM(MASK_DIM),
      .CANVAS_MAX(CANVAS_MAX)
   ) u_canvas_checker (
      .clock(clock),
      .reset(reset),
      .req_mon(req_bus),
      .rsp_mon(rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : receiver
      stall_mode_type mode;
      int unsigned span;
      int unsigned period;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         mode = stall_mode_type'($urandom_range(0, 2));
         span = $urandom_range(30, 200);
         period = $urandom_range(2, 12);
         for (int i = 0; i < span; i++) begin
            case (mode)
               STALL_NONE: rsp_bus.ready <= 1'b1;
               STALL_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= ((i % period) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   function automatic int unsigned source_extent(
         input logic [nnstc_pkg::SRC_REG_W-1:0] v);
      return (v == 0) ? 1 : ((v > MASK_DIM) ? MASK_DIM : v);
   endfunction

   function automatic int unsigned canvas_extent(
         input logic [nnstc_pkg::CANVAS_REG_W-1:0] v);
      return (v > CANVAS_MAX) ? CANVAS_MAX : v;
   endfunction

   // mask entry a read samples, or -1 when it falls outside the square
   function automatic int sampled_entry(input coord_type col, input coord_type row);
      int unsigned sw;
      int unsigned sh;
      int unsigned cw;
      int unsigned side;
      int unsigned off;
      int unsigned lx;
      int unsigned sx;
      int unsigned sy;
      sw = source_extent(cfg_src_w);
      sh = source_extent(cfg_src_h);
      cw = canvas_extent(cfg_canvas_w);
      side = canvas_extent(cfg_canvas_h);
      off = (cw > side) ? (cw - side) / 2 : 0;
      if (col >= cw || row >= side || col < off) return -1;
      lx = col - off;
      if (lx >= side) return -1;
      sy = (row * sh) / side;
      if (sy >= sh) sy = sh - 1;
      sx = (lx * sw) / side;
      if (sx >= sw) sx = sw - 1;
      return int'(sy * MASK_DIM + sx);
   endfunction

   function automatic csr_data_type pick_source_size();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return csr_data_type'($urandom_range(MASK_DIM + 1, 1023));
         2: return csr_data_type'(MASK_DIM);
         3: return csr_data_type'($urandom);
         default: return csr_data_type'($urandom_range(1, 24));
      endcase
   endfunction

   function automatic csr_data_type pick_canvas_size();
      case ($urandom_range(0, 11))
         0: return 0;
         1: return csr_data_type'($urandom);
         2: return csr_data_type'(CANVAS_MAX);
         3: return csr_data_type'($urandom_range(CANVAS_MAX - 64, CANVAS_MAX + 64));
         default: return csr_data_type'($urandom_range(1, 64));
      endcase
   endfunction

   task automatic send_beat(input logic op, input coord_type col,
                            input coord_type row, input pixel_type pixel);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.col <= col;
      req_bus.row <= row;
      req_bus.pixel <= pixel;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      beats_sent++;
      if (op == nnstc_pkg::OP_LOAD && col < MASK_DIM && row < MASK_DIM) begin
         loaded[row * MASK_DIM + col] = 1'b1;
      end
   endtask

   // never sample a mask entry that was not loaded: load it first
   task automatic read_pixel(input coord_type col, input coord_type row);
      int entry;
      entry = sampled_entry(col, row);
      if (entry >= 0 && !loaded[entry]) begin
         send_beat(nnstc_pkg::OP_LOAD, coord_type'(entry % MASK_DIM),
                   coord_type'(entry / MASK_DIM), pixel_type'($urandom));
      end
      send_beat(nnstc_pkg::OP_READ, col, row, pixel_type'($urandom));
   endtask

   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(input csr_index_type index, input csr_data_type data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(negedge clock);
      case (index)
         nnstc_pkg::CSR_SOURCE_WIDTH: cfg_src_w = data[nnstc_pkg::SRC_REG_W-1:0];
         nnstc_pkg::CSR_SOURCE_HEIGHT: cfg_src_h = data[nnstc_pkg::SRC_REG_W-1:0];
         nnstc_pkg::CSR_CANVAS_WIDTH: cfg_canvas_w = data[nnstc_pkg::CANVAS_REG_W-1:0];
         nnstc_pkg::CSR_CANVAS_HEIGHT: cfg_canvas_h = data[nnstc_pkg::CANVAS_REG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input csr_data_type sw, input csr_data_type sh,
                            input csr_data_type cw, input csr_data_type ch,
                            input csr_data_type chans);
      drain_pipeline();
      write_reg(csr_index_type'($urandom_range(CSR_UNUSED_LO, CSR_UNUSED_HI)),
                csr_data_type'($urandom));
      write_reg(nnstc_pkg::CSR_SOURCE_WIDTH, sw);
      write_reg(nnstc_pkg::CSR_SOURCE_HEIGHT, sh);
      write_reg(nnstc_pkg::CSR_CANVAS_WIDTH, cw);
      write_reg(nnstc_pkg::CSR_CANVAS_HEIGHT, ch);
      write_reg(nnstc_pkg::CSR_CHANNEL_COUNT, chans);
      write_reg(csr_index_type'($urandom_range(CSR_UNUSED_LO, CSR_UNUSED_HI)),
                csr_data_type'($urandom));
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned sw;
      int unsigned sh;
      int unsigned cw;
      int unsigned side;
      int unsigned off;
      int unsigned kind;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = nnstc_pkg::CSR_SOURCE_WIDTH;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.op = nnstc_pkg::OP_LOAD;
      req_bus.col = '0;
      req_bus.row = '0;
      req_bus.pixel = '0;
      cfg_src_w = nnstc_pkg::RST_SOURCE_WIDTH;
      cfg_src_h = nnstc_pkg::RST_SOURCE_HEIGHT;
      cfg_canvas_w = nnstc_pkg::RST_CANVAS_WIDTH;
      cfg_canvas_h = nnstc_pkg::RST_CANVAS_HEIGHT;
      burst_left = 0;
      beats_sent = 0;
      gaps_on = 1'b1;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset geometry: square of 1080 starting at column 420
      send_beat(nnstc_pkg::OP_LOAD, 0, 0, nnstc_pkg::BLACK);
      send_beat(nnstc_pkg::OP_LOAD, coord_type'(MASK_DIM - 1), coord_type'(MASK_DIM - 1),
                nnstc_pkg::WHITE);
      send_beat(nnstc_pkg::OP_LOAD, 4095, 0, 8'h5A);
      send_beat(nnstc_pkg::OP_LOAD, 0, coord_type'(MASK_DIM), 8'hA5);
      read_pixel(420, 0);
      read_pixel(1499, 1079);
      read_pixel(0, 0);
      read_pixel(1500, 0);
      read_pixel(4095, 4095);
      read_pixel(420, 1080);

      // threshold edge
      configure(4, 4, 8, 4, csr_data_type'(nnstc_pkg::RST_CHANNEL_COUNT));
      send_beat(nnstc_pkg::OP_LOAD, 1, 0, pixel_type'(nnstc_pkg::THRESH - 1));
      send_beat(nnstc_pkg::OP_LOAD, 2, 0, nnstc_pkg::THRESH);
      read_pixel(3, 0);
      read_pixel(4, 0);

      // two channels force white, other counts keep the byte
      configure(4, 4, 8, 4, csr_data_type'(nnstc_pkg::CHAN_FORCE_WHITE));
      send_beat(nnstc_pkg::OP_LOAD, 3, 3, nnstc_pkg::BLACK);
      read_pixel(5, 3);
      configure(4, 4, 8, 4, 5);
      send_beat(nnstc_pkg::OP_LOAD, 3, 3, nnstc_pkg::BLACK);
      read_pixel(5, 3);

      // saturated sizes
      configure(0, 1023, 8191, 8191, 0);
      read_pixel(4095, 4095);
      read_pixel(0, 0);

      // empty square
      configure(16, 16, 100, 0, 7);
      read_pixel(0, 0);
      read_pixel(50, 0);

      configure(1, 1, 1, 1, csr_data_type'(nnstc_pkg::RST_CHANNEL_COUNT));
      read_pixel(0, 0);
      read_pixel(1, 0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         configure(pick_source_size(), pick_source_size(), pick_canvas_size(),
                   pick_canvas_size(), csr_data_type'($urandom_range(0, 7)));
         gaps_on = ($urandom_range(0, 3) != 0);
         sw = source_extent(cfg_src_w);
         sh = source_extent(cfg_src_h);
         cw = canvas_extent(cfg_canvas_w);
         side = canvas_extent(cfg_canvas_h);
         off = (cw > side) ? (cw - side) / 2 : 0;
         while (beats_sent < ITEMS_PER_PHASE * (p + 1)) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
               send_beat(nnstc_pkg::OP_LOAD, coord_type'($urandom_range(0, sw - 1)),
                         coord_type'($urandom_range(0, sh - 1)), pixel_type'($urandom));
            end else if (kind < 40) begin
               send_beat(nnstc_pkg::OP_LOAD, coord_type'($urandom), coord_type'($urandom),
                         pixel_type'($urandom));
            end else if (kind < 70) begin
               read_pixel(coord_type'(off + $urandom_range(0, side)),
                          coord_type'($urandom_range(0, side)));
            end else if (kind < 85) begin
               read_pixel(coord_type'($urandom_range(0, cw)),
                          coord_type'($urandom_range(0, side)));
            end else begin
               read_pixel(coord_type'($urandom), coord_type'($urandom));
            end
         end
      end

      drain_pipeline();
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
